// ===== rtl/g2e_pkg.sv =====
// Shared types, constants and helper functions for the geodetic to ECEF converter.
package g2e_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int NEWTON_STEPS = 4;

    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
    localparam logic [32:0]        E2_Q40       = 33'd7360548640;
    localparam logic [32:0]        A_MM         = 33'd6378137000;
    localparam logic [30:0]        ONE_Q30      = 31'd1073741824;
    localparam logic [33:0]        Y_START      = 34'd2147483648;
    localparam logic [33:0]        THREE_Q31    = 34'd6442450944;
    localparam logic [66:0]        HALF_Q31     = 67'd1073741824;
    localparam logic signed [68:0] HALF_Q30     = 69'sd536870912;
    localparam logic [30:0]        W_MIN        = 31'd1066000000;

    // One rotator: vector, residual angle, half-turn flag
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic               flip;
    } t_rot;

    // Both rotators plus the height riding along
    typedef struct packed {
        t_rot               lat;
        t_rot               lon;
        logic signed [27:0] h;
    } t_cord;

    // Trig results and height carried beside the radius math
    typedef struct packed {
        logic signed [32:0] slat;
        logic signed [32:0] clat;
        logic signed [32:0] slon;
        logic signed [32:0] clon;
        logic signed [27:0] h;
    } t_side;

    // Inverse square root state
    typedef struct packed {
        logic [33:0] y;
        logic [30:0] w;
        t_side       side;
    } t_nwt;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Fold the angle into the right half plane and load the start vector
    function automatic t_rot rot_prep(input logic [31:0] angle);
        t_rot        r;
        logic [31:0] a;
        r.flip = angle[31] ^ angle[30];
        a      = r.flip ? angle + 32'h80000000 : angle;
        r.x    = CORDIC_START;
        r.y    = 33'sd0;
        r.z    = {{2{a[31]}}, a};
        return r;
    endfunction

    // floor((v*c + 2^29) / 2^30), low 34 bits
    function automatic logic signed [33:0] mul_q30(input logic signed [35:0] v,
                                                  input logic signed [32:0] c);
        logic signed [68:0] prod;
        logic signed [68:0] sum;
        prod = v * c;
        sum  = prod + HALF_Q30;
        return sum[63:30];
    endfunction

endpackage

// ===== rtl/g2e_cordic_cell.sv =====
// One CORDIC rotation step for latitude and longitude, registered.
module g2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  g2e_pkg::t_cord  i_data,
    output logic            o_valid,
    output g2e_pkg::t_cord  o_data
);

    logic           r_valid;
    g2e_pkg::t_cord r_data;
    g2e_pkg::t_cord n_data;

    // Turn toward zero residual angle
    function automatic g2e_pkg::t_rot rotate(input g2e_pkg::t_rot r);
        g2e_pkg::t_rot      o;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [33:0] at;
        dx = r.y >>> STEP;
        dy = r.x >>> STEP;
        at = {2'b00, g2e_pkg::atan_turn(STEP)};
        o  = r;
        if (!r.z[33]) begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - at;
        end else begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + at;
        end
        return o;
    endfunction

    always_comb begin
        n_data     = i_data;
        n_data.lat = rotate(i_data.lat);
        n_data.lon = rotate(i_data.lon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/g2e_newton_cell.sv =====
// One Newton step of the inverse square root, three registered stages.
module g2e_newton_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  g2e_pkg::t_nwt  i_data,
    output logic           o_valid,
    output g2e_pkg::t_nwt  o_data
);

    logic          r_va;
    logic          r_vb;
    logic          r_vc;
    g2e_pkg::t_nwt r_a;
    g2e_pkg::t_nwt r_b;
    g2e_pkg::t_nwt r_c;
    g2e_pkg::t_nwt n_c;
    logic [33:0]   r_y2;
    logic [33:0]   r_t;
    logic [67:0]   yy;
    logic [67:0]   wy;
    logic [67:0]   yt;
    logic [33:0]   diff;

    // y2 = y*y >> 31; t = w*y2 >> 30; y = y*(3*2^31 - t) >> 32
    always_comb begin
        yy   = {34'd0, i_data.y} * {34'd0, i_data.y};
        wy   = {37'd0, r_a.w} * {34'd0, r_y2};
        diff = g2e_pkg::THREE_Q31 - r_t;
        yt   = {34'd0, r_b.y} * {34'd0, diff};
        n_c   = r_b;
        n_c.y = yt[65:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= i_data;
            r_y2  <= yy[64:31];
            r_b   <= r_a;
            r_t   <= wy[63:30];
            r_c   <= n_c;
        end
    end

    assign o_valid = r_vc;
    assign o_data  = r_c;

endmodule

// ===== rtl/geodetic_to_ecef_wgs84_top.sv =====
// Top level: WGS84 geodetic position to Earth-centred X, Y, Z in millimetres.
//
//  channel  | dir | tdata fields (low bit first)
//  s_axis   | in  | longitude[31:0], latitude[63:32], height_mm[91:64]
//  m_axis   | out | x_mm[33:0], y_mm[67:34], z_mm[101:68]
//
// One transfer per cycle unless the pipeline holds; 30 CORDIC cells, 12 Newton
// stages (4 cells of 3) and 7 radius/product stages.
// Synchronous active-low reset clears only the valid bits.
// The whole pipeline advances together; it holds while a result waits
// on the output register and m_axis is not ready.
module geodetic_to_ecef_wgs84_top #(
    parameter int CORDIC_STEPS = g2e_pkg::CORDIC_STEPS,
    parameter int NEWTON_STEPS = g2e_pkg::NEWTON_STEPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,  // longitude, latitude, height_mm
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata   // x_mm, y_mm, z_mm
);

    logic en;

    logic           cv [CORDIC_STEPS+1];
    g2e_pkg::t_cord cd [CORDIC_STEPS+1];
    logic           nv [NEWTON_STEPS+1];
    g2e_pkg::t_nwt  nd [NEWTON_STEPS+1];

    logic          r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    g2e_pkg::t_side r_side1;
    logic [31:0]    r_s2;
    g2e_pkg::t_nwt  r_w2;
    g2e_pkg::t_side r_side3, r_side4, r_side5, r_side6;
    logic [33:0]    r_n3, r_n4, r_n5;
    logic [50:0]    r_pa;
    logic [32:0]    r_pb;
    logic signed [34:0] r_nh;
    logic [27:0]    r_e2n;
    logic signed [33:0] r_p;
    logic signed [34:0] r_zin;
    logic signed [33:0] r_x6, r_y6;
    logic signed [33:0] r_x7, r_y7, r_z7;

    logic signed [65:0] sq;
    logic [64:0]        ep;
    logic [66:0]        an;
    logic [50:0]        pa;
    logic [48:0]        pb;
    logic [51:0]        esum;

    assign en              = !r_v7 || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Input unpack and quadrant fold
    assign cd[0].lat = g2e_pkg::rot_prep(i_s_axis_tdata[63:32]);
    assign cd[0].lon = g2e_pkg::rot_prep(i_s_axis_tdata[31:0]);
    assign cd[0].h   = $signed(i_s_axis_tdata[91:64]);
    assign cv[0]     = i_s_axis_tvalid;

    // CORDIC chain
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        g2e_cordic_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[g]),
            .i_data  (cd[g]),
            .o_valid (cv[g+1]),
            .o_data  (cd[g+1])
        );
    end

    // Radius front end products
    always_comb begin
        sq   = cd[CORDIC_STEPS].lat.y * cd[CORDIC_STEPS].lat.y;
        ep   = {32'd0, g2e_pkg::E2_Q40} * {33'd0, r_s2};
        an   = {34'd0, g2e_pkg::A_MM} * {33'd0, nd[NEWTON_STEPS].y} + g2e_pkg::HALF_Q31;
        pa   = {18'd0, g2e_pkg::E2_Q40} * {33'd0, r_n3[33:16]};
        pb   = {16'd0, g2e_pkg::E2_Q40} * {33'd0, r_n3[15:0]};
        esum = {1'b0, r_pa} + {19'd0, r_pb};
    end

    // Valid bits of the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= cv[CORDIC_STEPS];
            r_v2 <= r_v1;
            r_v3 <= nv[NEWTON_STEPS];
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // Back end data path
    always_ff @(posedge i_clk) begin
        if (en) begin
            // undo the half-turn fold, square the latitude sine
            r_side1.clat <= cd[CORDIC_STEPS].lat.flip ? -cd[CORDIC_STEPS].lat.x
                                                      :  cd[CORDIC_STEPS].lat.x;
            r_side1.slat <= cd[CORDIC_STEPS].lat.flip ? -cd[CORDIC_STEPS].lat.y
                                                      :  cd[CORDIC_STEPS].lat.y;
            r_side1.clon <= cd[CORDIC_STEPS].lon.flip ? -cd[CORDIC_STEPS].lon.x
                                                      :  cd[CORDIC_STEPS].lon.x;
            r_side1.slon <= cd[CORDIC_STEPS].lon.flip ? -cd[CORDIC_STEPS].lon.y
                                                      :  cd[CORDIC_STEPS].lon.y;
            r_side1.h    <= cd[CORDIC_STEPS].h;
            r_s2         <= sq[61:30];
            // w = 1 - e2*sin^2
            r_w2.y       <= g2e_pkg::Y_START;
            r_w2.w       <= g2e_pkg::ONE_Q30 - {6'd0, ep[64:40]};
            r_w2.side    <= r_side1;
            // prime-vertical radius
            r_n3         <= an[64:31];
            r_side3      <= nd[NEWTON_STEPS].side;
            // e2*N partial products, N + h
            r_pa         <= pa;
            r_pb         <= pb[48:16];
            r_nh         <= $signed({1'b0, r_n3}) + 35'(r_side3.h);
            r_n4         <= r_n3;
            r_side4      <= r_side3;
            // e2*N, P = (N+h)cos(lat)
            r_e2n        <= esum[51:24];
            r_p          <= g2e_pkg::mul_q30(36'(r_nh), r_side4.clat);
            r_n5         <= r_n4;
            r_side5      <= r_side4;
            // X, Y and the Z radius term
            r_zin        <= $signed({1'b0, r_n5}) - $signed({7'd0, r_e2n}) + 35'(r_side5.h);
            r_x6         <= g2e_pkg::mul_q30(36'(r_p), r_side5.clon);
            r_y6         <= g2e_pkg::mul_q30(36'(r_p), r_side5.slon);
            r_side6      <= r_side5;
            // Z and output register
            r_z7         <= g2e_pkg::mul_q30(36'(r_zin), r_side6.slat);
            r_x7         <= r_x6;
            r_y7         <= r_y6;
        end
    end

    assign nv[0] = r_v2;
    assign nd[0] = r_w2;

    // Inverse square root chain
    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
        g2e_newton_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (nv[k]),
            .i_data  (nd[k]),
            .o_valid (nv[k+1]),
            .o_data  (nd[k+1])
        );
    end

    assign o_m_axis_tvalid = r_v7;
    assign o_m_axis_tdata  = {2'b00, r_z7, r_y7, r_x7};

    // Pipeline occupancy holds while stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_v1) && $stable(r_v3) && $stable(r_v6)))
        else $error("pipeline moved during stall");

    // w stays within the ellipsoid bounds
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_w2.w <= g2e_pkg::ONE_Q30 && r_w2.w >= g2e_pkg::W_MIN))
        else $error("w out of range");

    // Input is refused only while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without backpressure");

endmodule
